>>> hdl/audio_peak_limiter_unit_macros.svh
// assertion macros for the peak limiter checker
`ifndef AUDIO_PEAK_LIMITER_UNIT_MACROS_SVH
`define AUDIO_PEAK_LIMITER_UNIT_MACROS_SVH

// antecedent implies consequent in the next cycle
`define APL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define APL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/apl_pkg.sv
// shared types and constants of the peak limiter
`default_nettype none
package apl_pkg;

    localparam int NUM_LANES = 8;
    localparam int LANE_W    = 3;
    localparam logic [24:0] ONE_Q24 = 25'd16777216;

    // register reset values
    localparam logic        RST_ENABLE  = 1'b1;
    localparam logic [3:0]  RST_CHANS   = 4'd2;
    localparam logic [16:0] RST_CEILING = 17'd65536;
    localparam logic [23:0] RST_ATTACK  = 24'd16707456;
    localparam logic [23:0] RST_RELEASE = 24'd16773721;

    typedef enum logic [2:0] {
        REG_ENABLE  = 3'd0,
        REG_CHANS   = 3'd1,
        REG_CEILING = 3'd2,
        REG_ATTACK  = 3'd3,
        REG_RELEASE = 3'd4
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_PROCESS = 1'b0,
        OP_CLEAR   = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_ENV_PREV, ST_ENV_TGT, ST_ENV_WR, ST_DIV_INIT, ST_DIV,
        ST_GAIN_PREV, ST_GAIN_TGT, ST_GAIN_WR, ST_LANE_MUL, ST_LANE_WR, ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_ENV_PREV, MUL_ENV_TGT, MUL_GAIN_PREV, MUL_GAIN_TGT, MUL_LANE
    } mul_sel_t;

    typedef struct packed {
        logic              load;
        logic              res_clear;
        logic              res_copy;
        mul_sel_t          mul_sel;
        logic              acc_load;
        logic              env_write;
        logic              gain_write;
        logic              state_clear;
        logic              div_init;
        logic              div_step;
        logic              lane_write;
        logic              emit;
        logic [LANE_W-1:0] lane;
    } cmd_t;

    typedef struct packed {
        logic op_clear;
        logic n_zero;
        logic bypass;
        logic env_gt_ceil;
        logic lane_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

>>> hdl/audio_peak_limiter_unit.sv
// top level of the peak limiter: register port, sequencer and datapath
//
//  channel   direction   handshake                       payload
//  s_        in          s_valid / s_ready               operation, frame_len, sample_0..7
//  m_        out         m_valid / m_ready               out_0..7
//  apb       in          psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// a limited frame of n lanes runs the envelope update, then the gain divide when the
// envelope exceeds the ceiling (one quotient bit per cycle in the divider), then the
// gain update and the lanes, which the shared multiplier serializes; a clear, empty
// or bypass frame skips these; one new item is taken per frame; the result waits in an
// output register, so the next item is taken while it is pending; reset is synchronous, active low
`default_nettype none
module audio_peak_limiter_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [3:0]         s_frame_len,
    input  wire logic signed [15:0] s_sample_0,
    input  wire logic signed [15:0] s_sample_1,
    input  wire logic signed [15:0] s_sample_2,
    input  wire logic signed [15:0] s_sample_3,
    input  wire logic signed [15:0] s_sample_4,
    input  wire logic signed [15:0] s_sample_5,
    input  wire logic signed [15:0] s_sample_6,
    input  wire logic signed [15:0] s_sample_7,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_out_0,
    output logic signed [15:0]      m_out_1,
    output logic signed [15:0]      m_out_2,
    output logic signed [15:0]      m_out_3,
    output logic signed [15:0]      m_out_4,
    output logic signed [15:0]      m_out_5,
    output logic signed [15:0]      m_out_6,
    output logic signed [15:0]      m_out_7
);

    logic               enable_reg;
    logic [3:0]         chans_reg;
    logic [16:0]        ceiling_reg;
    logic [23:0]        attack_reg;
    logic [23:0]        release_reg;
    logic               wr_en;
    apl_pkg::reg_idx_t  idx;
    apl_pkg::cmd_t      cmd;
    apl_pkg::status_t   status;
    logic signed [15:0] in_sample [apl_pkg::NUM_LANES];
    logic signed [15:0] out_sample [apl_pkg::NUM_LANES];

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = apl_pkg::reg_idx_t'(paddr[4:2]);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= apl_pkg::RST_ENABLE;
            chans_reg   <= apl_pkg::RST_CHANS;
            ceiling_reg <= apl_pkg::RST_CEILING;
            attack_reg  <= apl_pkg::RST_ATTACK;
            release_reg <= apl_pkg::RST_RELEASE;
        end else if (wr_en) begin
            unique case (idx)
                apl_pkg::REG_ENABLE:  enable_reg  <= pwdata[0];
                apl_pkg::REG_CHANS:   chans_reg   <= pwdata[3:0];
                apl_pkg::REG_CEILING: ceiling_reg <= pwdata[16:0];
                apl_pkg::REG_ATTACK:  attack_reg  <= pwdata[23:0];
                apl_pkg::REG_RELEASE: release_reg <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (idx)
            apl_pkg::REG_ENABLE:  prdata = {31'b0, enable_reg};
            apl_pkg::REG_CHANS:   prdata = {28'b0, chans_reg};
            apl_pkg::REG_CEILING: prdata = {15'b0, ceiling_reg};
            apl_pkg::REG_ATTACK:  prdata = {8'b0, attack_reg};
            apl_pkg::REG_RELEASE: prdata = {8'b0, release_reg};
            default:              prdata = '0;
        endcase
    end

    // lane packing
    assign in_sample[0] = s_sample_0;
    assign in_sample[1] = s_sample_1;
    assign in_sample[2] = s_sample_2;
    assign in_sample[3] = s_sample_3;
    assign in_sample[4] = s_sample_4;
    assign in_sample[5] = s_sample_5;
    assign in_sample[6] = s_sample_6;
    assign in_sample[7] = s_sample_7;
    assign m_out_0 = out_sample[0];
    assign m_out_1 = out_sample[1];
    assign m_out_2 = out_sample[2];
    assign m_out_3 = out_sample[3];
    assign m_out_4 = out_sample[4];
    assign m_out_5 = out_sample[5];
    assign m_out_6 = out_sample[6];
    assign m_out_7 = out_sample[7];

    apl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    apl_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_enable   (enable_reg),
        .cfg_chans    (chans_reg),
        .cfg_ceiling  (ceiling_reg),
        .cfg_attack   (attack_reg),
        .cfg_release  (release_reg),
        .in_operation (s_operation),
        .in_frame_len (s_frame_len),
        .in_sample    (in_sample),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .out_sample   (out_sample)
    );

endmodule
`default_nettype wire

>>> hdl/apl_ctrl.sv
// sequencer of the peak limiter
`default_nettype none
module apl_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire apl_pkg::status_t status,
    output apl_pkg::cmd_t         cmd
);

    apl_pkg::state_t state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;

    // state and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= apl_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.mul_sel = apl_pkg::MUL_NONE;
        cmd.lane    = cnt_reg[apl_pkg::LANE_W-1:0];
        s_ready     = 1'b0;
        unique case (state_reg)
            apl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = apl_pkg::ST_DECIDE;
                end
            end
            apl_pkg::ST_DECIDE: begin
                cmd.res_clear = 1'b1;
                if (status.op_clear) begin
                    cmd.state_clear = 1'b1;
                    state_next      = apl_pkg::ST_EMIT;
                end else if (status.n_zero) begin
                    state_next = apl_pkg::ST_EMIT;
                end else if (status.bypass) begin
                    cmd.res_copy = 1'b1;
                    state_next   = apl_pkg::ST_EMIT;
                end else begin
                    state_next = apl_pkg::ST_ENV_PREV;
                end
            end
            apl_pkg::ST_ENV_PREV: begin
                cmd.mul_sel = apl_pkg::MUL_ENV_PREV;
                state_next  = apl_pkg::ST_ENV_TGT;
            end
            apl_pkg::ST_ENV_TGT: begin
                cmd.mul_sel  = apl_pkg::MUL_ENV_TGT;
                cmd.acc_load = 1'b1;
                state_next   = apl_pkg::ST_ENV_WR;
            end
            apl_pkg::ST_ENV_WR: begin
                cmd.env_write = 1'b1;
                state_next    = apl_pkg::ST_DIV_INIT;
            end
            apl_pkg::ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                if (status.env_gt_ceil) begin
                    cnt_next   = 5'd23;
                    state_next = apl_pkg::ST_DIV;
                end else begin
                    state_next = apl_pkg::ST_GAIN_PREV;
                end
            end
            apl_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = apl_pkg::ST_GAIN_PREV;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            apl_pkg::ST_GAIN_PREV: begin
                cmd.mul_sel = apl_pkg::MUL_GAIN_PREV;
                state_next  = apl_pkg::ST_GAIN_TGT;
            end
            apl_pkg::ST_GAIN_TGT: begin
                cmd.mul_sel  = apl_pkg::MUL_GAIN_TGT;
                cmd.acc_load = 1'b1;
                state_next   = apl_pkg::ST_GAIN_WR;
            end
            apl_pkg::ST_GAIN_WR: begin
                cmd.gain_write = 1'b1;
                cnt_next       = '0;
                state_next     = apl_pkg::ST_LANE_MUL;
            end
            apl_pkg::ST_LANE_MUL: begin
                cmd.mul_sel = apl_pkg::MUL_LANE;
                state_next  = apl_pkg::ST_LANE_WR;
            end
            apl_pkg::ST_LANE_WR: begin
                cmd.lane_write = 1'b1;
                if (status.lane_last) begin
                    state_next = apl_pkg::ST_EMIT;
                end else begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = apl_pkg::ST_LANE_MUL;
                end
            end
            apl_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = apl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = apl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/apl_dp.sv
// datapath of the peak limiter: envelope, gain, divider, lane scaling
`default_nettype none
module apl_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire apl_pkg::cmd_t       cmd,
    output apl_pkg::status_t         status,
    input  wire logic                cfg_enable,
    input  wire logic [3:0]          cfg_chans,
    input  wire logic [16:0]         cfg_ceiling,
    input  wire logic [23:0]         cfg_attack,
    input  wire logic [23:0]         cfg_release,
    input  wire logic                in_operation,
    input  wire logic [3:0]          in_frame_len,
    input  wire logic signed [15:0]  in_sample [apl_pkg::NUM_LANES],
    input  wire logic                m_ready,
    output logic                     m_valid,
    output logic signed [15:0]       out_sample [apl_pkg::NUM_LANES]
);

    logic              op_reg;
    logic [3:0]        n_reg;
    logic signed [15:0] smp_reg [apl_pkg::NUM_LANES];
    logic [24:0]       peak_reg;
    logic [25:0]       env_reg;
    logic [25:0]       gain_reg;
    logic [50:0]       prod_reg;
    logic [50:0]       acc_reg;
    logic [25:0]       rem_reg;
    logic [24:0]       target_reg;
    logic signed [15:0] res_reg [apl_pkg::NUM_LANES];
    logic signed [15:0] out_reg [apl_pkg::NUM_LANES];
    logic              m_valid_reg;

    logic [3:0]        chans;
    logic [3:0]        n_next;
    logic [24:0]       peak_next;
    logic [24:0]       ceil24;
    logic [23:0]       env_coef;
    logic [23:0]       gain_coef;
    logic [24:0]       mul_a;
    logic [25:0]       mul_b;
    logic [51:0]       blend_sum;
    logic [25:0]       blend_val;
    logic [26:0]       rem_shift;
    logic [26:0]       rem_diff;
    logic [26:0]       lane_mag;
    logic [26:0]       lane_clip;
    logic [15:0]       lane_limit;
    logic [16:0]       lane_cap;
    logic signed [15:0] lane_res;
    logic              lane_neg;

    function automatic logic [16:0] mag_of(input logic signed [15:0] x);
        logic signed [16:0] e;
        e = {x[15], x};
        return x[15] ? 17'(-e) : 17'(e);
    endfunction

    // effective frame length
    always_comb begin
        if (cfg_chans == 4'd0) begin
            chans = 4'd1;
        end else if (cfg_chans > 4'(apl_pkg::NUM_LANES)) begin
            chans = 4'(apl_pkg::NUM_LANES);
        end else begin
            chans = cfg_chans;
        end
        n_next = (in_frame_len > chans) ? chans : in_frame_len;
    end

    // frame peak over valid lanes, magnitude in Q1.24
    always_comb begin
        peak_next = '0;
        for (int i = 0; i < apl_pkg::NUM_LANES; i++) begin
            if (4'(i) < n_reg && (25'(mag_of(smp_reg[i])) << 9) > peak_next) begin
                peak_next = 25'(mag_of(smp_reg[i])) << 9;
            end
        end
    end

    // coefficient choice and multiplier operands
    assign ceil24    = {cfg_ceiling, 8'b0};
    assign env_coef  = ({1'b0, peak_reg} > env_reg) ? cfg_attack : cfg_release;
    assign gain_coef = ({1'b0, target_reg} < gain_reg) ? cfg_attack : cfg_release;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            apl_pkg::MUL_ENV_PREV: begin
                mul_a = {1'b0, env_coef};
                mul_b = env_reg;
            end
            apl_pkg::MUL_ENV_TGT: begin
                mul_a = apl_pkg::ONE_Q24 - {1'b0, env_coef};
                mul_b = {1'b0, peak_reg};
            end
            apl_pkg::MUL_GAIN_PREV: begin
                mul_a = {1'b0, gain_coef};
                mul_b = gain_reg;
            end
            apl_pkg::MUL_GAIN_TGT: begin
                mul_a = apl_pkg::ONE_Q24 - {1'b0, gain_coef};
                mul_b = {1'b0, target_reg};
            end
            apl_pkg::MUL_LANE: begin
                mul_a = {8'b0, mag_of(smp_reg[cmd.lane])};
                mul_b = gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one-pole blend of the two registered products
    assign blend_sum = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign blend_val = blend_sum[49:24];

    // restoring divide step
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, env_reg};

    // lane scaling, clip to ceiling, saturate
    always_comb begin
        lane_neg   = smp_reg[cmd.lane][15];
        lane_mag   = prod_reg[50:24];
        lane_limit = cfg_ceiling[16:1];
        lane_clip  = (lane_mag > {11'b0, lane_limit}) ? {11'b0, lane_limit} : lane_mag;
        if (lane_neg) begin
            lane_cap = (lane_clip > 27'd32768) ? 17'd32768 : lane_clip[16:0];
            lane_res = 16'(17'h10000 - lane_cap);
        end else begin
            lane_cap = (lane_clip > 27'd32767) ? 17'd32767 : lane_clip[16:0];
            lane_res = lane_cap[15:0];
        end
    end

    // item capture and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_operation;
            n_reg   <= n_next;
            smp_reg <= in_sample;
        end
        peak_reg <= peak_next;
        if (cmd.mul_sel != apl_pkg::MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_load) begin
            acc_reg <= prod_reg;
        end
        if (cmd.div_init) begin
            rem_reg    <= {1'b0, ceil24};
            target_reg <= status.env_gt_ceil ? '0 : apl_pkg::ONE_Q24;
        end else if (cmd.div_step) begin
            if (!rem_diff[26]) begin
                rem_reg    <= rem_diff[25:0];
                target_reg <= {target_reg[23:0], 1'b1};
            end else begin
                rem_reg    <= rem_shift[25:0];
                target_reg <= {target_reg[23:0], 1'b0};
            end
        end
        for (int i = 0; i < apl_pkg::NUM_LANES; i++) begin
            if (cmd.res_clear) begin
                res_reg[i] <= (cmd.res_copy && 4'(i) < n_reg) ? smp_reg[i] : '0;
            end else if (cmd.lane_write && cmd.lane == apl_pkg::LANE_W'(i)) begin
                res_reg[i] <= lane_res;
            end
        end
        if (cmd.emit) begin
            out_reg <= res_reg;
        end
    end

    // limiter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg  <= '0;
            gain_reg <= {1'b0, apl_pkg::ONE_Q24};
        end else if (cmd.state_clear) begin
            env_reg  <= '0;
            gain_reg <= {1'b0, apl_pkg::ONE_Q24};
        end else begin
            if (cmd.env_write) begin
                env_reg <= blend_val;
            end
            if (cmd.gain_write) begin
                gain_reg <= blend_val;
            end
        end
    end

    // output item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // status to sequencer
    always_comb begin
        status.op_clear    = (op_reg == apl_pkg::OP_CLEAR);
        status.n_zero      = (n_reg == 4'd0);
        status.bypass      = !cfg_enable;
        status.env_gt_ceil = (env_reg > {1'b0, ceil24});
        status.lane_last   = ({1'b0, cmd.lane} + 4'd1 == n_reg);
        status.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid    = m_valid_reg;
    assign out_sample = out_reg;

endmodule
`default_nettype wire

>>> hdl/apl_checker.sv
// port-level checks of the peak limiter and their binding
`default_nettype none
`include "audio_peak_limiter_unit_macros.svh"
module apl_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready
);

    // a pending result holds until taken
    `APL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // one frame in work at a time
    `APL_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "item taken while busy")

    // a new result only appears from a busy block
    `APL_ASSERT_SAME(a_out_from_work, $rose(m_valid), !$past(s_ready),
        "result without work")

endmodule

bind audio_peak_limiter_unit apl_checker u_apl_checker (.*);
`default_nettype wire
